@@ hdl/bnds_pkg.sv @@
// ----------------------------------------------------------------------------
// bnds_pkg
// Shared types, constants and arithmetic helpers of the multilevel
// blue-noise dot screen.
// ----------------------------------------------------------------------------
package bnds_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_INK      = 3'd0;
	localparam logic [2:0] REG_SMALL_BASE   = 3'd1;
	localparam logic [2:0] REG_MEDIUM_BASE  = 3'd2;
	localparam logic [2:0] REG_SPAN_COLOUR  = 3'd3;
	localparam logic [2:0] REG_PEAK_COLOUR  = 3'd4;
	localparam logic [2:0] REG_SPAN_BLACK   = 3'd5;
	localparam logic [2:0] REG_PEAK_BLACK   = 3'd6;
	localparam logic [2:0] REG_SWAP_ENABLE  = 3'd7;

	// Dot classes
	typedef logic [1:0] dot_t;
	localparam dot_t DOT_NONE   = 2'd0;
	localparam dot_t DOT_SMALL  = 2'd1;
	localparam dot_t DOT_MEDIUM = 2'd2;
	localparam dot_t DOT_LARGE  = 2'd3;

	// Screen constants
	localparam logic [7:0] FULL_TONE       = 8'd255;
	localparam logic [7:0] MIN_INK_CAP     = 8'd254;
	localparam logic [6:0] SPAN_MAX        = 7'd64;
	localparam logic [3:0] PEAK_MAX        = 4'd8;
	localparam logic [7:0] SMALL_CUT_LO    = 8'd64;
	localparam logic [7:0] MEDIUM_CUT_LO   = 8'd130;
	localparam logic [7:0] SWAP_LO         = 8'd96;
	localparam logic [7:0] SWAP_HI         = 8'd160;
	localparam logic [7:0] SMALL_BASE_RST  = 8'd64;
	localparam logic [7:0] MEDIUM_BASE_RST = 8'd130;

	// Hash constants
	localparam logic [31:0] HASH_SEED = 32'h51F2F90D;
	localparam logic [31:0] HASH_MX   = 32'h85EBCA6B;
	localparam logic [31:0] HASH_MY   = 32'hC2B2AE35;
	localparam logic [31:0] HASH_XOR  = 32'h27D4EB2D;
	localparam logic [31:0] HASH_M1   = 32'h7FEB352D;
	localparam logic [31:0] HASH_M2   = 32'h846CA68B;

	// Reciprocal of 255, exact for any 16-bit dividend
	localparam logic [32:0] RECIP_255 = 33'd32897;

	// Pipeline stage advance strobes shared with the hash unit
	typedef struct packed {
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} bnds_adv_t;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [32:0] m;
		m = {17'd0, x} * RECIP_255;
		return m[30:23];
	endfunction

	// One restoring division step: {quotient bit, new remainder}
	function automatic logic [8:0] div_step(input logic [7:0] r, input logic b,
			input logic [7:0] d);
		logic [8:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			return {1'b1, t[7:0]};
		end else begin
			return {1'b0, t[7:0]};
		end
	endfunction

endpackage

@@ hdl/bnds_if.sv @@
// ----------------------------------------------------------------------------
// bnds_if
// Channel interfaces of the dot screen: pixel input, dot output and
// configuration write.
// ----------------------------------------------------------------------------
interface bnds_in_if #(parameter int COORD_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [7:0]            ink_tone;
	logic [7:0]            noise_sample;
	logic [COORD_BITS-1:0] column;
	logic [COORD_BITS-1:0] row_index;
	logic                  black_plane;

	modport source(output valid, ink_tone, noise_sample, column, row_index, black_plane,
		input ready);
	modport sink(input valid, ink_tone, noise_sample, column, row_index, black_plane,
		output ready);
endinterface

interface bnds_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] dot_class;

	modport source(output valid, dot_class, input ready);
	modport sink(input valid, dot_class, output ready);
endinterface

interface bnds_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] reg_index;
	logic [7:0] wdata;

	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

@@ hdl/bnds_hash.sv @@
// ----------------------------------------------------------------------------
// bnds_hash
// Per-pixel coordinate hash over four stages: two multiplies in stage one, one
// in each of stages two and three; stage four holds the final mix's low byte.
// ----------------------------------------------------------------------------
module bnds_hash #(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  bnds_pkg::bnds_adv_t   adv,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row_index,
	output logic [7:0]            hash_s4
);
	import bnds_pkg::*;

	logic [31:0] hx_s1;
	logic [31:0] hy_s1;
	logic [31:0] h_s2;
	logic [31:0] h_s3;
	logic [31:0] mix1;
	logic [31:0] mix2;

	always_comb begin
		mix1 = hx_s1 ^ hy_s1 ^ HASH_XOR ^ HASH_SEED;
		mix1 = mix1 ^ (mix1 >> 16);
		mix2 = h_s2 ^ (h_s2 >> 15);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			hx_s1 <= 32'(column) * HASH_MX;
			hy_s1 <= 32'(row_index) * HASH_MY;
		end
		if (adv.s2) begin
			h_s2 <= mix1 * HASH_M1;
		end
		if (adv.s3) begin
			h_s3 <= mix2 * HASH_M2;
		end
		if (adv.s4) begin
			hash_s4 <= h_s3[7:0] ^ h_s3[23:16];
		end
	end

endmodule

@@ hdl/blue_noise_multilevel_dot_screen.sv @@
// ----------------------------------------------------------------------------
// blue_noise_multilevel_dot_screen
// Multilevel blue-noise threshold screen: one ink pixel in, one 2-bit dot
// class out, with highlight floor bias and low-tone small/large swap.
// ----------------------------------------------------------------------------
// Pipeline: five register stages, s1 to s5, the first loaded at the pixel
// transaction edge; the dot class is driven from the last of them.
// Throughput: one pixel per cycle while the output is not stalled; the dividers
// are split so that each stage holds at most four divide steps.
// An output stall holds each occupied stage behind it; empty stages still fill.
// Reset clears all stage valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module blue_noise_multilevel_dot_screen #(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	bnds_in_if.sink    pix_in,
	bnds_out_if.source dot_out,
	bnds_cfg_if.sink   cfg
);
	import bnds_pkg::*;

	// Configuration registers
	logic [7:0] min_ink_q;
	logic [7:0] small_base_q;
	logic [7:0] medium_base_q;
	logic [6:0] span_col_q;
	logic [3:0] peak_col_q;
	logic [6:0] span_blk_q;
	logic [3:0] peak_blk_q;
	logic       swap_en_q;

	// Stage enables
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	bnds_adv_t adv;

	// Stage 1
	logic        valid_s1, gate_s1, zone_all_s1, zone_hash_s1;
	logic [15:0] num_s1, rel_num_s1, scut_num_s1, mcut_num_s1;
	logic [7:0]  den_s1, noise_s1, swp_p_s1;
	logic [6:0]  span_s1;
	logic [3:0]  peak_s1;

	// Stage 2
	logic        valid_s2, gate_s2, zone_all_s2, zone_hash_s2;
	logic [7:0]  rem_s2, den_s2, noise_s2, rel_s2, scut_s2, mcut_s2, swp_p_s2;
	logic [3:0]  qhi_s2, nlo_s2, peak_s2;
	logic [6:0]  span_s2;

	// Stage 3
	logic        valid_s3, gate_s3, zone_all_s3, zone_hash_s3;
	logic [7:0]  eff_s3, noise_s3, swp_p_s3;
	logic [6:0]  span_s3;
	logic [3:0]  peak_s3;
	dot_t        cls_s3;

	// Stage 4
	logic        valid_s4, gate_s4, act_s4, zone_all_s4, zone_hash_s4;
	logic [7:0]  eff_s4, noise_s4, swp_p_s4, hash_s4;
	logic [9:0]  fnum_s4;
	logic [6:0]  span_s4;
	dot_t        cls_s4;

	// Stage 5 (output register)
	logic        valid_s5;
	dot_t        dot_class_s5;

	// Stage 1 logic
	logic [7:0]  minl, diff, tone, noise;
	logic [6:0]  span_raw, span_c;
	logic [3:0]  peak_raw, peak_c;
	logic        gate_c;
	logic [15:0] num_c;

	// Stage 2 / 3 / 4 / 5 logic
	logic [7:0]  r2, r3, r5;
	logic [8:0]  st2, st3, st5;
	logic [3:0]  q2, q3, q5, bias;
	logic        act_c;
	logic [6:0]  sdiff;
	logic [8:0]  eff_sum;
	logic [7:0]  eff_sat;
	logic        pass, hit, do_swap;
	dot_t        cls_c, cls_sw;

	assign en_s5 = !valid_s5 || dot_out.ready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign adv.s1 = en_s1;
	assign adv.s2 = en_s2;
	assign adv.s3 = en_s3;
	assign adv.s4 = en_s4;

	assign pix_in.ready    = en_s1;
	assign cfg.ready       = 1'b1;
	assign dot_out.valid     = valid_s5;
	assign dot_out.dot_class = dot_class_s5;

	// Configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ink_q     <= '0;
			small_base_q  <= SMALL_BASE_RST;
			medium_base_q <= MEDIUM_BASE_RST;
			span_col_q    <= '0;
			peak_col_q    <= '0;
			span_blk_q    <= '0;
			peak_blk_q    <= '0;
			swap_en_q     <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_MIN_INK:     min_ink_q     <= cfg.wdata;
				REG_SMALL_BASE:  small_base_q  <= cfg.wdata;
				REG_MEDIUM_BASE: medium_base_q <= cfg.wdata;
				REG_SPAN_COLOUR: span_col_q    <= cfg.wdata[6:0];
				REG_PEAK_COLOUR: peak_col_q    <= cfg.wdata[3:0];
				REG_SPAN_BLACK:  span_blk_q    <= cfg.wdata[6:0];
				REG_PEAK_BLACK:  peak_blk_q    <= cfg.wdata[3:0];
				REG_SWAP_ENABLE: swap_en_q     <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= pix_in.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: renormalise numerator, floor select, cut blend products
	always_comb begin
		tone     = pix_in.ink_tone;
		noise    = pix_in.noise_sample;
		minl     = (min_ink_q > MIN_INK_CAP) ? MIN_INK_CAP : min_ink_q;
		gate_c   = tone > minl;
		diff     = tone - minl;
		num_c    = gate_c ? ({diff, 8'd0} - {8'd0, diff}) : '0;
		span_raw = pix_in.black_plane ? span_blk_q : span_col_q;
		peak_raw = pix_in.black_plane ? peak_blk_q : peak_col_q;
		span_c   = (span_raw > SPAN_MAX) ? SPAN_MAX : span_raw;
		peak_c   = (peak_raw > PEAK_MAX) ? PEAK_MAX : peak_raw;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			gate_s1      <= gate_c;
			num_s1       <= num_c;
			den_s1       <= FULL_TONE - minl;
			span_s1      <= span_c;
			peak_s1      <= peak_c;
			noise_s1     <= noise;
			rel_num_s1   <= 16'(noise) * 16'(tone);
			scut_num_s1  <= 16'(FULL_TONE - tone) * 16'(SMALL_CUT_LO)
				+ 16'(tone) * 16'(small_base_q);
			mcut_num_s1  <= 16'(FULL_TONE - tone) * 16'(MEDIUM_CUT_LO)
				+ 16'(tone) * 16'(medium_base_q);
			zone_all_s1  <= tone < SWAP_LO;
			zone_hash_s1 <= (tone >= SWAP_LO) && (tone < SWAP_HI);
			swp_p_s1     <= 8'((16'(SWAP_HI - tone) * 16'(FULL_TONE)) >> 6);
		end
	end

	// Stage 2: upper quotient nibble, scale mask and cuts by 1/255
	always_comb begin
		r2 = num_s1[15:8];
		q2 = '0;
		st2 = '0;
		for (int i = 0; i < 4; i++) begin
			st2 = div_step(r2, num_s1[7-i], den_s1);
			q2[3-i] = st2[8];
			r2 = st2[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			gate_s2      <= gate_s1;
			rem_s2       <= r2;
			qhi_s2       <= q2;
			nlo_s2       <= num_s1[3:0];
			den_s2       <= den_s1;
			span_s2      <= span_s1;
			peak_s2      <= peak_s1;
			noise_s2     <= noise_s1;
			rel_s2       <= div255(rel_num_s1);
			scut_s2      <= div255(scut_num_s1);
			mcut_s2      <= div255(mcut_num_s1);
			zone_all_s2  <= zone_all_s1;
			zone_hash_s2 <= zone_hash_s1;
			swp_p_s2     <= swp_p_s1;
		end
	end

	// Stage 3: lower quotient nibble, dot size classification
	always_comb begin
		r3 = rem_s2;
		q3 = '0;
		st3 = '0;
		for (int i = 0; i < 4; i++) begin
			st3 = div_step(r3, nlo_s2[3-i], den_s2);
			q3[3-i] = st3[8];
			r3 = st3[7:0];
		end
		if (rel_s2 <= scut_s2) begin
			cls_c = DOT_SMALL;
		end else if (rel_s2 <= mcut_s2) begin
			cls_c = DOT_MEDIUM;
		end else begin
			cls_c = DOT_LARGE;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			gate_s3      <= gate_s2;
			eff_s3       <= {qhi_s2, q3};
			cls_s3       <= cls_c;
			span_s3      <= span_s2;
			peak_s3      <= peak_s2;
			noise_s3     <= noise_s2;
			zone_all_s3  <= zone_all_s2;
			zone_hash_s3 <= zone_hash_s2;
			swp_p_s3     <= swp_p_s2;
		end
	end

	// Stage 4: highlight floor numerator
	always_comb begin
		act_c = (span_s3 != '0) && (peak_s3 != '0) && (eff_s3 < {1'b0, span_s3});
		sdiff = span_s3 - eff_s3[6:0];
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			gate_s4      <= gate_s3;
			eff_s4       <= eff_s3;
			act_s4       <= act_c;
			fnum_s4      <= act_c ? (10'(peak_s3) * 10'(sdiff)) : '0;
			span_s4      <= span_s3;
			noise_s4     <= noise_s3;
			cls_s4       <= cls_s3;
			zone_all_s4  <= zone_all_s3;
			zone_hash_s4 <= zone_hash_s3;
			swp_p_s4     <= swp_p_s3;
		end
	end

	bnds_hash #(
		.COORD_BITS(COORD_BITS)
	) u_hash (
		.clk      (clk),
		.adv      (adv),
		.column   (pix_in.column),
		.row_index(pix_in.row_index),
		.hash_s4  (hash_s4)
	);

	// Stage 5: floor bias, screen test, low-tone swap
	always_comb begin
		r5 = {2'b00, fnum_s4[9:4]};
		q5 = '0;
		st5 = '0;
		for (int i = 0; i < 4; i++) begin
			st5 = div_step(r5, fnum_s4[3-i], {1'b0, span_s4});
			q5[3-i] = st5[8];
			r5 = st5[7:0];
		end
		bias    = act_s4 ? q5 : '0;
		eff_sum = {1'b0, eff_s4} + {5'd0, bias};
		eff_sat = eff_sum[8] ? FULL_TONE : eff_sum[7:0];
		pass    = gate_s4 && (eff_sat > noise_s4);
		hit     = hash_s4 < swp_p_s4;
		do_swap = swap_en_q && (zone_all_s4 || (zone_hash_s4 && hit));
		cls_sw  = do_swap ? 2'(3'd4 - {1'b0, cls_s4}) : cls_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			dot_class_s5 <= pass ? cls_sw : DOT_NONE;
		end
	end

`ifndef ASSERT_OFF
	a_no_ink_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		en_s5 && valid_s4 && !gate_s4 |=> dot_class_s5 == DOT_NONE)
		else $error("pixel at or below minimum ink produced a dot");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && gate_s2 |-> rem_s2 < den_s2)
		else $error("divider partial remainder out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !en_s3 |=> valid_s3 && $stable(eff_s3) && $stable(cls_s3))
		else $error("stage 3 changed while stalled");
`endif

endmodule

@@ sim/blue_noise_multilevel_dot_screen_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blue_noise_multilevel_dot_screen_tb
// Self-checking bench for the multilevel blue-noise dot screen. A short
// stimulus table covers tone and mask extremes, the highlight floor, the
// minimum-ink cap and the low-tone swap. Random pixels then run under several
// register settings, with bursty input and a stalling output. Each dot class
// is checked in order against the table's expected class or a local model.
// ----------------------------------------------------------------------------
module blue_noise_multilevel_dot_screen_tb;
	import bnds_pkg::*;

	localparam int CRD = 16;

	typedef struct packed {
		logic [7:0]     ink_tone;
		logic [7:0]     noise_sample;
		logic [CRD-1:0] column;
		logic [CRD-1:0] row_index;
		logic           black_plane;
	} pixel_t;

	typedef struct packed {
		logic [7:0] min_ink;
		logic [7:0] small_base;
		logic [7:0] medium_base;
		logic [6:0] span_colour;
		logic [3:0] peak_colour;
		logic [6:0] span_black;
		logic [3:0] peak_black;
		logic       swap_en;
	} screen_cfg_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [2:0] reg_idx;
		logic [7:0] wdata;
		pixel_t     pix;
		logic       typed;
		dot_t       dot;
	} stim_row_t;

	localparam int N_ROWS = 31;

	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd0, 8'd0, 16'h0000, 16'h0000, 1'b0}, 1'b1, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd255, 16'h0000, 16'h0000, 1'b0}, 1'b1,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
			DOT_SMALL},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd100, 16'h0000, 16'hFFFF, 1'b0}, 1'b1,
			DOT_MEDIUM},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd254, 16'hFFFF, 16'h0000, 1'b1}, 1'b1,
			DOT_LARGE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd1, 8'd0, 16'h0000, 16'h0000, 1'b0}, 1'b1, DOT_SMALL},
		'{ROW_WRITE, REG_SWAP_ENABLE, 8'd1, '0, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd50, 8'd0, 16'h0000, 16'h0000, 1'b1}, 1'b1,
			DOT_LARGE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd120, 8'd30, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd159, 8'd10, 16'h1234, 16'h0000, 1'b0}, 1'b0,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd96, 8'd200, 16'h0000, 16'h0001, 1'b0}, 1'b0,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd160, 8'd10, 16'h0005, 16'h0005, 1'b0}, 1'b1,
			DOT_SMALL},
		'{ROW_WRITE, REG_MIN_INK, 8'd255, '0, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd254, 8'd0, 16'h00FF, 16'hFF00, 1'b0}, 1'b1,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd0, 16'hFF00, 16'h00FF, 1'b1}, 1'b1,
			DOT_SMALL},
		'{ROW_WRITE, REG_MIN_INK, 8'd0, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_SPAN_COLOUR, 8'h7F, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_PEAK_COLOUR, 8'h0F, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_SPAN_BLACK, 8'd64, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_PEAK_BLACK, 8'd1, '0, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd1, 8'd7, 16'hAAAA, 16'h5555, 1'b0}, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd1, 8'd1, 16'h5555, 16'hAAAA, 1'b1}, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd40, 8'd45, 16'h0F0F, 16'hF0F0, 1'b0}, 1'b0,
			DOT_NONE},
		'{ROW_WRITE, REG_SMALL_BASE, 8'd0, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_MEDIUM_BASE, 8'd255, '0, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd255, 8'd128, 16'h8000, 16'h0001, 1'b1}, 1'b0,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd128, 8'd60, 16'h0001, 16'h8000, 1'b0}, 1'b0,
			DOT_NONE},
		'{ROW_WRITE, REG_SMALL_BASE, 8'd255, '0, 1'b0, DOT_NONE},
		'{ROW_WRITE, REG_MEDIUM_BASE, 8'd0, '0, 1'b0, DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd200, 8'd199, 16'hFFFF, 16'h0000, 1'b0}, 1'b0,
			DOT_NONE},
		'{ROW_PIXEL, REG_MIN_INK, 8'd0, '{8'd100, 8'd150, 16'h3C3C, 16'hC3C3, 1'b1}, 1'b0,
			DOT_NONE}
	};

	logic clk;
	logic arst_n;

	bnds_in_if #(.COORD_BITS(CRD)) pix_if();
	bnds_out_if dot_if();
	bnds_cfg_if cfg_if();

	blue_noise_multilevel_dot_screen #(.COORD_BITS(CRD)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.dot_out (dot_if),
		.cfg     (cfg_if)
	);

	screen_cfg_t scr_cfg;
	dot_t        expected_dots[$];
	int          fail_count = 0;
	logic        typed_valid;
	dot_t        typed_dot;
	int          burst_left;
	int          rx_mode;
	int          rx_left;
	int          rx_tick;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [31:0] pixel_hash(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] h;
		h = (x * HASH_MX) ^ (y * HASH_MY) ^ HASH_XOR ^ HASH_SEED;
		h = h ^ (h >> 16);
		h = h * HASH_M1;
		h = h ^ (h >> 15);
		h = h * HASH_M2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic dot_t classify_dot(input screen_cfg_t c, input pixel_t p);
		int unsigned tone, noise, minl, span, peak, eff, rel, scut, mcut, cls, prob;
		logic [31:0] h;
		tone  = p.ink_tone;
		noise = p.noise_sample;
		minl  = (c.min_ink > MIN_INK_CAP) ? MIN_INK_CAP : c.min_ink;
		span  = p.black_plane ? c.span_black : c.span_colour;
		peak  = p.black_plane ? c.peak_black : c.peak_colour;
		if (span > SPAN_MAX) span = SPAN_MAX;
		if (peak > PEAK_MAX) peak = PEAK_MAX;
		if (tone <= minl) return DOT_NONE;
		eff = (tone - minl) * 255 / (255 - minl);
		if (span > 0 && peak > 0 && eff < span) begin
			eff = eff + peak * (span - eff) / span;
			if (eff > 255) eff = 255;
		end
		if (eff <= noise) return DOT_NONE;
		rel  = noise * tone / 255;
		scut = ((255 - tone) * SMALL_CUT_LO + tone * c.small_base) / 255;
		mcut = ((255 - tone) * MEDIUM_CUT_LO + tone * c.medium_base) / 255;
		if (rel <= scut) cls = DOT_SMALL;
		else if (rel <= mcut) cls = DOT_MEDIUM;
		else cls = DOT_LARGE;
		if (c.swap_en) begin
			if (tone < SWAP_LO) begin
				cls = 4 - cls;
			end else if (tone < SWAP_HI) begin
				prob = (SWAP_HI - tone) * 255 / (SWAP_HI - SWAP_LO);
				h = pixel_hash({16'd0, p.column}, {16'd0, p.row_index});
				if (h[7:0] < prob) cls = 4 - cls;
			end
		end
		return dot_t'(cls);
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [7:0] data);
		case (idx)
			REG_MIN_INK:     scr_cfg.min_ink     = data;
			REG_SMALL_BASE:  scr_cfg.small_base  = data;
			REG_MEDIUM_BASE: scr_cfg.medium_base = data;
			REG_SPAN_COLOUR: scr_cfg.span_colour = data[6:0];
			REG_PEAK_COLOUR: scr_cfg.peak_colour = data[3:0];
			REG_SPAN_BLACK:  scr_cfg.span_black  = data[6:0];
			REG_PEAK_BLACK:  scr_cfg.peak_black  = data[3:0];
			REG_SWAP_ENABLE: scr_cfg.swap_en     = data[0];
			default: ;
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int     t;
		p.noise_sample = 8'($urandom_range(0, 255));
		p.column       = CRD'($urandom);
		p.row_index    = CRD'($urandom);
		p.black_plane  = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: t = $urandom_range(90, 165);
			1: t = scr_cfg.min_ink + $urandom_range(0, 3);
			default: t = $urandom_range(0, 255);
		endcase
		p.ink_tone = (t > 255) ? 8'd255 : 8'(t);
		return p;
	endfunction

	function automatic logic [7:0] phase_wdata(input int ph);
		if (ph == 0) return 8'h00;
		if (ph == 1) return 8'hFF;
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// drive at the falling edge, return at the falling edge after the transaction
	task automatic send_pixel(input pixel_t p);
		if (burst_left == 0) begin
			pix_if.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		pix_if.valid        = 1'b1;
		pix_if.ink_tone     = p.ink_tone;
		pix_if.noise_sample = p.noise_sample;
		pix_if.column       = p.column;
		pix_if.row_index    = p.row_index;
		pix_if.black_plane  = p.black_plane;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pix_if.valid = 1'b0;
		burst_left = 0;
		while (expected_dots.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_if.valid     = 1'b1;
		cfg_if.reg_index = idx;
		cfg_if.wdata     = data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (dot_if.valid && dot_if.ready) begin
				if (expected_dots.size() == 0) begin
					$error("dot_class: unexpected transaction, actual %0d", dot_if.dot_class);
					fail_count++;
				end else if (dot_if.dot_class !== expected_dots[0]) begin
					$error("dot_class mismatch: expected %0d, actual %0d", expected_dots[0],
						dot_if.dot_class);
					fail_count++;
					void'(expected_dots.pop_front());
				end else begin
					void'(expected_dots.pop_front());
				end
			end
			if (pix_if.valid && pix_if.ready) begin
				if (typed_valid) expected_dots.push_back(typed_dot);
				else expected_dots.push_back(classify_dot(scr_cfg, {pix_if.ink_tone,
					pix_if.noise_sample, pix_if.column, pix_if.row_index,
					pix_if.black_plane}));
			end
		end
	end

	// output stalls: full rate, mostly ready, mostly stalled, periodic
	always @(negedge clk) begin
		if (!arst_n) begin
			dot_if.ready <= 1'b0;
			rx_mode = 0;
			rx_left = 0;
			rx_tick = 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				0: dot_if.ready <= 1'b1;
				1: dot_if.ready <= ($urandom_range(0, 3) != 0);
				2: dot_if.ready <= ($urandom_range(0, 3) == 0);
				default: dot_if.ready <= (rx_tick % 3 != 0);
			endcase
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		stim_row_t r;
		arst_n              = 1'b0;
		pix_if.valid        = 1'b0;
		pix_if.ink_tone     = '0;
		pix_if.noise_sample = '0;
		pix_if.column       = '0;
		pix_if.row_index    = '0;
		pix_if.black_plane  = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.reg_index    = REG_MIN_INK;
		cfg_if.wdata        = '0;
		typed_valid         = 1'b0;
		typed_dot           = DOT_NONE;
		burst_left          = 0;
		scr_cfg             = '{8'd0, SMALL_BASE_RST, MEDIUM_BASE_RST, 7'd0, 4'd0, 7'd0,
			4'd0, 1'b0};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			r = DIRECTED_ROWS[i];
			if (r.kind == ROW_WRITE) begin
				wait_drained();
				write_reg(r.reg_idx, r.wdata);
			end else begin
				typed_valid = r.typed;
				typed_dot   = r.dot;
				send_pixel(r.pix);
			end
		end
		typed_valid = 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			for (int k = 0; k < 8; k++) write_reg(3'(k), phase_wdata(ph));
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 49) == 0) wait_drained();
				send_pixel(random_pixel());
			end
		end

		pix_if.valid = 1'b0;
		while (expected_dots.size() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
